FILE: hdl/iqrf_pkg.sv
package iqrf_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int MAX_BLOCK   = 32;
  localparam int MAX_REPEAT  = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int WORD_W  = 16;
  localparam int REP_W   = $clog2(MAX_REPEAT + 1);
  localparam int BLK_W   = $clog2(MAX_BLOCK + 1);
  localparam int CNT_W   = (REP_W > BLK_W) ? REP_W : BLK_W;
  localparam int CMP_W   = ((ADDR_W > CNT_W) ? ADDR_W : CNT_W) + 1;
  localparam int CFG_W   = 7;
  localparam int QIDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [15:0] i_sample;
    logic signed [15:0] q_sample;
    logic [5:0]         block_pairs;
  } in_t;

  typedef struct packed {
    logic signed [7:0] out_i;
    logic signed [7:0] out_q;
    logic              accepted;
    logic              underrun;
    logic              last;
  } out_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: hdl/iqrf_ram.sv
module iqrf_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/iqrf_front.sv
module iqrf_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  iqrf_pkg::in_t         cmd_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [6:0]            cfg_data_i,
  input  iqrf_pkg::q_status_t   q_status_i,
  output logic                  q_push_o,
  output iqrf_pkg::cmd_t        q_data_o
);
  import iqrf_pkg::*;

  logic [CFG_W-1:0] repeat_q;
  logic [CFG_W-1:0] repeat_d;
  logic [REP_W-1:0] rep_eff;
  logic [BLK_W-1:0] blk_eff;
  logic             drop;

  assign cfg_ready_o = 1'b1;
  assign repeat_d    = cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_q <= CFG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      repeat_q <= repeat_d;
    end
  end

  // Zero repeat counts as one; repeat and block counts above MAX_REPEAT and MAX_BLOCK saturate.
  always_comb begin
    if (repeat_q == '0) begin
      rep_eff = REP_W'(1);
    end else if (int'(repeat_q) > MAX_REPEAT) begin
      rep_eff = REP_W'(MAX_REPEAT);
    end else begin
      rep_eff = REP_W'(repeat_q);
    end
    if (int'(cmd_i.block_pairs) > MAX_BLOCK) begin
      blk_eff = BLK_W'(MAX_BLOCK);
    end else begin
      blk_eff = BLK_W'(cmd_i.block_pairs);
    end
  end

  assign busy = q_status_i.full;

  // A pull of zero pairs is taken and retired here without a result.
  assign drop     = (cmd_i.op == OP_PULL) && (cmd_i.block_pairs == '0);
  assign q_push_o = start && !busy && !drop;

  always_comb begin
    q_data_o.op   = cmd_i.op;
    q_data_o.word = {cmd_i.i_sample[15:8], cmd_i.q_sample[15:8]};
    if (cmd_i.op == OP_PUSH) begin
      q_data_o.count = CNT_W'(rep_eff);
    end else begin
      q_data_o.count = CNT_W'(blk_eff);
    end
  end

endmodule

FILE: hdl/iqrf_cmd_queue.sv
module iqrf_cmd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  iqrf_pkg::cmd_t      push_data_i,
  input  logic                pop_i,
  output iqrf_pkg::cmd_t      pop_data_o,
  output iqrf_pkg::q_status_t status_o
);
  import iqrf_pkg::*;

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_sel_q, wr_sel_d;
  logic [QIDX_W-1:0] rd_sel_q, rd_sel_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = slot_q[rd_sel_q];

  always_comb begin
    wr_sel_d = wr_sel_q;
    rd_sel_d = rd_sel_q;
    count_d  = count_q;
    if (do_push) begin
      wr_sel_d = (wr_sel_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_sel_q + QIDX_W'(1);
    end
    if (do_pop) begin
      rd_sel_d = (rd_sel_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_sel_q + QIDX_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_sel_q <= '0;
      rd_sel_q <= '0;
      count_q  <= '0;
    end else begin
      wr_sel_q <= wr_sel_d;
      rd_sel_q <= rd_sel_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_sel_q] <= push_data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("command queue count out of range");

  a_pop_moves_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> count_q == $past(count_q) - QCNT_W'(1))
    else $error("command queue pop did not lower the count");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(status_o.full && status_o.empty))
    else $error("command queue full and empty at once");

endmodule

FILE: hdl/iqrf_back.sv
module iqrf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iqrf_pkg::q_status_t q_status_i,
  input  iqrf_pkg::cmd_t      q_data_i,
  output logic                q_pop_o,
  output logic                res_strobe_o,
  output iqrf_pkg::out_t      res_o
);
  import iqrf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_HOLD,
    ST_READ
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [WORD_W-1:0] word_q;
  logic [ADDR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [ADDR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [ADDR_W-1:0] used_q;
  logic [7:0]        held_i_q;
  logic [7:0]        held_q_q;
  out_t              res_q;
  logic              res_valid_q;
  logic              rd_tag_valid_q;
  logic              rd_tag_last_q;

  logic              ram_we;
  logic              ram_re;
  logic [WORD_W-1:0] rdata;
  logic [CMP_W-1:0]  space;
  logic [CMP_W-1:0]  used_ext;
  logic [CMP_W-1:0]  cnt_ext;

  assign q_pop_o  = (state_q == ST_IDLE) && !q_status_i.empty;
  assign ram_we   = (state_q == ST_WRITE);
  assign ram_re   = (state_q == ST_READ);
  assign used_ext = CMP_W'(used_q);
  assign space    = CMP_W'(STORE_DEPTH - 1) - used_ext;
  assign cnt_ext  = CMP_W'(q_data_i.count);
  assign wr_ptr_d = (wr_ptr_q == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wr_ptr_q + ADDR_W'(1);
  assign rd_ptr_d = (rd_ptr_q == ADDR_W'(STORE_DEPTH - 1)) ? '0 : rd_ptr_q + ADDR_W'(1);

  iqrf_ram #(
    .Width(WORD_W),
    .Depth(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_ptr_q),
    .wdata_i(word_q),
    .re_i   (ram_re),
    .raddr_i(rd_ptr_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      word_q         <= '0;
      wr_ptr_q       <= '0;
      rd_ptr_q       <= '0;
      used_q         <= '0;
      held_i_q       <= '0;
      held_q_q       <= '0;
      res_q          <= '0;
      res_valid_q    <= 1'b0;
      rd_tag_valid_q <= 1'b0;
      rd_tag_last_q  <= 1'b0;
    end else begin
      res_valid_q    <= ((state_q == ST_IDLE) && q_pop_o && (q_data_i.op == OP_PUSH)) ||
                        (state_q == ST_HOLD);
      rd_tag_valid_q <= (state_q == ST_READ);
      rd_tag_last_q  <= (state_q == ST_READ) && (cnt_q == CNT_W'(1));

      // The final popped pair of a block becomes the held pair.
      if (rd_tag_valid_q && rd_tag_last_q) begin
        held_i_q <= rdata[15:8];
        held_q_q <= rdata[7:0];
      end

      unique case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            cnt_q  <= q_data_i.count;
            word_q <= q_data_i.word;
            if (q_data_i.op == OP_PUSH) begin
              res_q <= out_t'{out_i: '0, out_q: '0, accepted: (space >= cnt_ext),
                              underrun: 1'b0, last: 1'b1};
              if (space >= cnt_ext) begin
                state_q <= ST_WRITE;
              end
            end else if (used_ext < cnt_ext) begin
              state_q <= ST_HOLD;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        ST_WRITE: begin
          wr_ptr_q <= wr_ptr_d;
          used_q   <= used_q + ADDR_W'(1);
          cnt_q    <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_HOLD: begin
          res_q <= out_t'{out_i: held_i_q, out_q: held_q_q, accepted: 1'b0,
                          underrun: 1'b1, last: (cnt_q == CNT_W'(1))};
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_READ: begin
          rd_ptr_q <= rd_ptr_d;
          used_q   <= used_q - ADDR_W'(1);
          cnt_q    <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Popped pairs go out straight from the store's read register.
  assign res_strobe_o = res_valid_q || rd_tag_valid_q;

  always_comb begin
    if (rd_tag_valid_q) begin
      res_o.out_i    = rdata[15:8];
      res_o.out_q    = rdata[7:0];
      res_o.accepted = 1'b0;
      res_o.underrun = 1'b0;
      res_o.last     = rd_tag_last_q;
    end else begin
      res_o = res_q;
    end
  end

  a_one_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_valid_q && rd_tag_valid_q))
    else $error("two result sources active in one cycle");

  a_read_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> used_q != '0)
    else $error("store read with no stored pair");

  a_write_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> used_q != ADDR_W'(STORE_DEPTH - 1))
    else $error("store write with no free slot");

  a_held_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_tag_valid_q && rd_tag_last_q) |=> {held_i_q, held_q_q} == $past(rdata))
    else $error("held pair not taken from the final popped pair");

endmodule

FILE: hdl/iq_replay_fifo_with_hold.sv
// Circular store of 8-bit I/Q pairs with hold on underrun. A command is
// taken when start is high and busy is low; busy rises only while the
// two-entry command queue is full. The back end has one store write port
// and one read port and runs one command at a time: an accepted push with
// repeat factor r takes one decision step, then r writes, a refused push
// takes only the decision step, and a pull of n pairs takes the decision
// step, then n reads or n held-pair results. Results arrive on res_o for
// exactly one cycle each, marked by res_strobe_o, and cannot be held off.
// A pull of zero pairs is taken and gives no result. The store needs no
// clearing after reset.
module iq_replay_fifo_with_hold (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  iqrf_pkg::in_t  cmd_i,
  output logic           res_strobe_o,
  output iqrf_pkg::out_t res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [6:0]     cfg_data_i
);
  import iqrf_pkg::*;

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  cmd_t      q_in;
  cmd_t      q_out;

  iqrf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .q_status_i (q_status),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  iqrf_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_in),
    .pop_i      (q_pop),
    .pop_data_o (q_out),
    .status_o   (q_status)
  );

  iqrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_data_i    (q_out),
    .q_pop_o     (q_pop),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

endmodule

FILE: tb/sv/iq_replay_checker.sv
`timescale 1ns / 100ps
module iq_replay_checker
  import iqrf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  in_t              cmd_i,
  input  logic             res_strobe_i,
  input  out_t             res_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int               fail_count_o,
  output int               due_count_o,
  output int               stored_pairs_o,
  output int               checked_count_o,
  output int               underrun_count_o,
  output int               refused_count_o
);

  logic [WORD_W-1:0] pair_store [STORE_DEPTH];
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] rd_ptr;
  logic [7:0]        held_i;
  logic [7:0]        held_q;
  logic [CFG_W-1:0]  repeat_reg;
  out_t              results_due [$];

  task automatic apply_push(input in_t c);
    int                rep;
    logic [ADDR_W-1:0] used;
    logic [7:0]        pi;
    logic [7:0]        pq;
    out_t              r;
    rep  = int'(repeat_reg);
    used = wr_ptr - rd_ptr;
    pi   = c.i_sample[15:8];
    pq   = c.q_sample[15:8];
    r    = '0;
    r.last = 1'b1;
    if (rep == 0) rep = 1;
    if (rep > MAX_REPEAT) rep = MAX_REPEAT;
    // The pair is written either in full or not at all.
    if (STORE_DEPTH - 1 - int'(used) >= rep) begin
      repeat (rep) begin
        pair_store[wr_ptr] = {pi, pq};
        wr_ptr = wr_ptr + ADDR_W'(1);
      end
      r.accepted = 1'b1;
    end else begin
      refused_count_o++;
    end
    results_due.push_back(r);
  endtask

  task automatic apply_pull(input in_t c);
    int                n;
    logic [ADDR_W-1:0] used;
    out_t              r;
    n    = int'(c.block_pairs);
    used = wr_ptr - rd_ptr;
    r    = '0;
    if (n > MAX_BLOCK) n = MAX_BLOCK;
    for (int k = 0; k < n; k++) begin
      r = '0;
      r.last = (k == n - 1);
      if (int'(used) < n) begin
        r.out_i    = held_i;
        r.out_q    = held_q;
        r.underrun = 1'b1;
      end else begin
        {r.out_i, r.out_q} = pair_store[rd_ptr];
        rd_ptr = rd_ptr + ADDR_W'(1);
      end
      results_due.push_back(r);
    end
    if (n != 0 && int'(used) >= n) begin
      held_i = r.out_i;
      held_q = r.out_q;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t              want;
    logic [ADDR_W-1:0] fill;
    if (!rst_ni) begin
      wr_ptr           = '0;
      rd_ptr           = '0;
      held_i           = '0;
      held_q           = '0;
      repeat_reg       = 7'd1;
      results_due.delete();
      fail_count_o     = 0;
      checked_count_o  = 0;
      underrun_count_o = 0;
      refused_count_o  = 0;
      due_count_o      <= 0;
      stored_pairs_o   <= 0;
    end else begin
      if (res_strobe_i) begin
        checked_count_o++;
        if (results_due.size() == 0) begin
          $error("result with nothing due: out_i 0x%02h out_q 0x%02h last %b",
                 res_i.out_i, res_i.out_q, res_i.last);
          fail_count_o++;
        end else begin
          want = results_due.pop_front();
          check_field("out_i", want.out_i, res_i.out_i);
          check_field("out_q", want.out_q, res_i.out_q);
          check_field("accepted", 8'(want.accepted), 8'(res_i.accepted));
          check_field("underrun", 8'(want.underrun), 8'(res_i.underrun));
          check_field("last", 8'(want.last), 8'(res_i.last));
          if (want.underrun) underrun_count_o++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) repeat_reg = cfg_data_i;
      if (start_i && !busy_i) begin
        if (cmd_i.op == OP_PUSH) apply_push(cmd_i);
        else apply_pull(cmd_i);
      end
      fill = wr_ptr - rd_ptr;
      due_count_o    <= results_due.size();
      stored_pairs_o <= int'(fill);
    end
  end

endmodule

FILE: tb/sv/iq_replay_fifo_with_hold_tb.sv
`timescale 1ns / 100ps
module iq_replay_fifo_with_hold_tb;
  import iqrf_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 25;
  localparam logic [CFG_W-1:0] REPEAT_PLAN [9] = '{
    7'd4, 7'd1, 7'd64, 7'd127, 7'd2, 7'd0, 7'd8, 7'd65, 7'd3
  };

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  in_t              cmd       = '0;
  logic             res_strobe;
  out_t             res;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  int fail_count;
  int due_count;
  int stored_pairs;
  int checked_count;
  int underrun_count;
  int refused_count;
  int idle_pct    = 0;
  int sent_count  = 0;
  int cycle_count = 0;

  iq_replay_fifo_with_hold DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd),
    .res_strobe_o(res_strobe),
    .res_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  iq_replay_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .cmd_i           (cmd),
    .res_strobe_i    (res_strobe),
    .res_i           (res),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .due_count_o     (due_count),
    .stored_pairs_o  (stored_pairs),
    .checked_count_o (checked_count),
    .underrun_count_o(underrun_count),
    .refused_count_o (refused_count)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Returns at the edge where the command transfer takes place, with start still high.
  task automatic send_cmd(input in_t c);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic send_push(input logic [15:0] i_val, input logic [15:0] q_val);
    in_t c;
    c.op          = OP_PUSH;
    c.i_sample    = i_val;
    c.q_sample    = q_val;
    c.block_pairs = 6'($urandom_range(0, 63));
    send_cmd(c);
  endtask

  task automatic send_pull(input logic [5:0] n);
    in_t c;
    c.op          = OP_PULL;
    c.i_sample    = 16'($urandom);
    c.q_sample    = 16'($urandom);
    c.block_pairs = n;
    send_cmd(c);
  endtask

  // An accepted push gives its result before its writes are done, so the block
  // may still be busy once the last result is in; the extra cycles cover that.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (due_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_repeat(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Steers the fill level toward a target that moves now and then, so the
  // store swings between empty (underrun) and full (refused pushes).
  task automatic run_random(input int n);
    int  target;
    int  pick;
    in_t c;
    target = $urandom_range(0, STORE_DEPTH - 1);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) target = $urandom_range(0, STORE_DEPTH - 1);
      c.i_sample = 16'($urandom);
      c.q_sample = 16'($urandom);
      c.op = ($urandom_range(0, 99) < ((stored_pairs < target) ? 80 : 20)) ? OP_PUSH : OP_PULL;
      pick = $urandom_range(0, 99);
      if (pick < 4) c.block_pairs = 6'd0;
      else if (pick < 12) c.block_pairs = 6'($urandom_range(MAX_BLOCK + 1, 63));
      else if (pick < 50) c.block_pairs = 6'($urandom_range(1, 8));
      else c.block_pairs = 6'($urandom_range(1, MAX_BLOCK));
      send_cmd(c);
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_pct = 16;

    // Pull from an empty store shows the reset value of the held pair.
    send_pull(6'd1);
    send_pull(6'd0);
    send_push(16'h7FFF, 16'h8000);
    send_push(16'h8000, 16'h7FFF);
    send_push(16'h00FF, 16'hFF00);
    send_pull(6'd63);
    send_pull(6'd3);
    send_pull(6'd2);

    // Largest repeat count fills the store until a push is refused.
    write_repeat(7'd64);
    repeat (16) send_push(16'($urandom), 16'($urandom));
    send_pull(6'd32);
    write_repeat(7'd0);
    send_push(16'h1234, 16'hEDCB);
    send_pull(6'd1);

    for (int mode = 0; mode < 3; mode++) begin
      idle_pct = (mode == 0) ? 16 : (mode == 1) ? 60 : 0;
      for (int k = 0; k < 3; k++) begin
        write_repeat(REPEAT_PLAN[mode * 3 + k]);
        run_random(PHASE_ITEMS);
      end
    end

    wait_idle();
    $display("Sent %0d commands at repeat factors 0 to 127; checked %0d results.",
             sent_count, checked_count);
    $display("Saw %0d held-pair results on underrun and %0d refused pushes.",
             underrun_count, refused_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
